// ----- rtl/twf_pkg.sv -----
// Shared types, constants and helper functions for the tape wow/flutter block.
// Used by twf_lane and tape_wow_flutter_saturation; depends on nothing else.
`default_nettype none

package twf_pkg;

    localparam int LINE_LENGTH     = 2048;
    localparam int SAMPLE_RATE     = 48000;
    localparam int BASE_DELAY      = 576;
    localparam int SINE_TABLE_SIZE = 1024;

    // Widest line index carried between the control and the lanes (8192 entries).
    localparam int CMD_ADDR_W = 13;
    localparam int ACC_W      = 42;

    localparam logic [62:0] NUM_IDENTITY = 63'h2000_0000_0000_0000;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    typedef enum logic [3:0] {
        REG_WOW_DEPTH     = 4'd0,
        REG_FLUTTER_DEPTH = 4'd1,
        REG_SAT_AMOUNT    = 4'd2,
        REG_WET_MIX       = 4'd3,
        REG_SHELF_NUM     = 4'd4,
        REG_SHELF_DEN     = 4'd5,
        REG_BUMP_NUM      = 4'd6,
        REG_BUMP_DEN      = 4'd7
    } twf_reg_t;

    // Settings seen by both lanes; index 0 is the shelf, index 1 the head bump.
    typedef struct packed {
        logic [16:0]      sat_s;
        logic [19:0]      drive;
        logic [16:0]      mix;
        logic             mix_full;
        logic [1:0][62:0] num;
        logic [1:0][47:0] den;
    } twf_cfg_t;

    typedef struct packed {
        logic                  start;
        logic [CMD_ADDR_W-1:0] wr_addr;
        logic [CMD_ADDR_W-1:0] rd_addr0;
        logic [CMD_ADDR_W-1:0] rd_addr1;
        logic                  ok0;
        logic                  ok1;
        logic [15:0]           frac;
    } twf_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -ACC_W'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [23:0] r;
        if (v > ACC_W'(64'sd8388607)) begin
            r = 24'sh7F_FFFF;
        end else if (v < -ACC_W'(64'sd8388608)) begin
            r = 24'sh80_0000;
        end else begin
            r = 24'(v);
        end
        return r;
    endfunction

    // Sine of a 32-bit phase word (one turn = 2^32) as Q1.15, by a Taylor series
    // on the first quadrant. Evaluated only on constants to build the table.
    function automatic logic signed [15:0] sine_from_u(input logic [31:0] u);
        logic [1:0] quad;
        longint     r;
        longint     x;
        longint     x2;
        longint     t;
        longint     s;
        quad = u[31:30];
        r = longint'({2'b00, u[29:0]});
        if (quad[0]) begin
            r = ONE_Q30 - r;
        end
        x  = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        s  = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        if (quad[1]) begin
            s = -s;
        end
        return 16'(s);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tape_wow_flutter_saturation.sv -----
// Tape emulation top level: configuration registers, wow/flutter oscillators,
// read position, two channel lanes and the output register.
// Depends on twf_pkg, twf_lane and twf_ram.
//
// Usage:
//  s_tvalid/s_tready/s_tdata carry one stereo request: left_in in bits 23:0,
//  right_in in bits 47:24, both signed Q1.23. m_tvalid/m_tready/m_tdata return
//  left_out in bits 23:0 and right_out in bits 47:24.
//  cfg_valid/cfg_ready/cfg_index/cfg_data write one setting; cfg_ready is always
//  high and unknown indexes are ignored. Write settings only while idle.
//  A processed request goes from acceptance to m_tvalid through the oscillators
//  and the read position, the start of the lanes, the lane sequence, whose length
//  is set by the 24-step soft clip divider and the ten biquad multiplies on the
//  single multiplier of each lane, and the load of the output register. Both
//  channels run side by side.
//  A bypassed request (mix zero or all settings neutral) goes straight to T_OUT.
//  One request is in work at a time; a new one is accepted while the previous
//  result still waits in the output register.
//  When the receiver stalls, the result holds in the output register and the
//  block stops before loading the next result.
//  Reset restores the default settings, zeroes oscillators, filter state and
//  write position; delay entries not yet written read as zero.
`default_nettype none

module tape_wow_flutter_saturation #(
    parameter int LINE_LENGTH     = twf_pkg::LINE_LENGTH,
    parameter int SAMPLE_RATE     = twf_pkg::SAMPLE_RATE,
    parameter int BASE_DELAY      = twf_pkg::BASE_DELAY,
    parameter int SINE_TABLE_SIZE = twf_pkg::SINE_TABLE_SIZE
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // left_in [23:0], right_in [47:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // left_out [23:0], right_out [47:24]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int AW    = $clog2(LINE_LENGTH);
    localparam int SW    = $clog2(SINE_TABLE_SIZE);
    localparam int OFF_W = 40;
    localparam logic [31:0] WOW_INC = 32'(((64'd7 << 32) + 64'd5 * SAMPLE_RATE)
                                          / (64'd10 * SAMPLE_RATE));
    localparam logic [31:0] FLUTTER_INC = 32'(((64'd9 << 32) + SAMPLE_RATE / 2)
                                              / SAMPLE_RATE);
    localparam logic signed [OFF_W-1:0] SPAN   = OFF_W'(LINE_LENGTH) <<< 16;
    localparam logic signed [OFF_W-1:0] BASE_Q = OFF_W'(BASE_DELAY) <<< 16;

    typedef enum logic [8:0] {
        T_IDLE  = 9'h001,
        T_SINEW = 9'h002,
        T_SINEF = 9'h004,
        T_MULT  = 9'h008,
        T_OFFS  = 9'h010,
        T_POS   = 9'h020,
        T_ADDR  = 9'h040,
        T_LANES = 9'h080,
        T_OUT   = 9'h100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [15:0] wow_depth_reg;
    logic [12:0] flutter_depth_reg;
    logic [16:0] sat_amount_reg;
    logic [16:0] wet_mix_reg;
    logic [62:0] shelf_num_reg, bump_num_reg;
    logic [47:0] shelf_den_reg, bump_den_reg;

    logic [31:0]             wow_phase_reg, flutter_phase_reg;
    logic [AW-1:0]           wi_reg;
    logic                    wrapped_reg;
    logic signed [23:0]      dry_l_reg, dry_r_reg;
    logic                    bypass_reg;
    logic signed [15:0]      sine_reg;
    logic signed [32:0]      wow_term_reg, fl_term_reg;
    logic signed [OFF_W-1:0] offset_reg, pos_reg;
    twf_pkg::twf_cmd_t       cmd_reg;
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;

    logic signed [15:0]      sine_rom [SINE_TABLE_SIZE];
    logic [SW-1:0]           wow_idx, fl_idx;
    twf_pkg::twf_cfg_t       cfg;
    logic [16:0]             sat_s, mix_c;
    logic                    neutral, bypass_c, in_acc;
    logic signed [OFF_W-1:0] p0, p_add1, p_add2, p_sub1, pos_c;
    logic [AW-1:0]           i0_c, i1_c;
    logic                    done_l, done_r;
    logic signed [23:0]      res_l, res_r;

    genvar k;
    generate
        for (k = 0; k < SINE_TABLE_SIZE; k++)
        begin : g_sine
            localparam logic [31:0] U = 32'((64'(k) << 32) / SINE_TABLE_SIZE);
            assign sine_rom[k] = twf_pkg::sine_from_u(U);
        end
    endgenerate

    assign wow_idx = SW'((64'(wow_phase_reg) * SINE_TABLE_SIZE) >> 32);
    assign fl_idx  = SW'((64'(flutter_phase_reg) * SINE_TABLE_SIZE) >> 32);

    assign sat_s = (sat_amount_reg > 17'd65536) ? 17'd65536 : sat_amount_reg;
    assign mix_c = (wet_mix_reg > 17'd65536) ? 17'd65536 : wet_mix_reg;

    always_comb
    begin
        cfg.sat_s    = sat_s;
        cfg.drive    = 20'd65536 + 20'(sat_s) * 20'd7;
        cfg.mix      = mix_c;
        cfg.mix_full = (mix_c == 17'd65536);
        cfg.num      = {bump_num_reg, shelf_num_reg};
        cfg.den      = {bump_den_reg, shelf_den_reg};
    end

    assign neutral = (wow_depth_reg == '0) && (flutter_depth_reg == '0) && (sat_s == '0)
                  && (shelf_num_reg == twf_pkg::NUM_IDENTITY) && (shelf_den_reg == '0)
                  && (bump_num_reg == twf_pkg::NUM_IDENTITY) && (bump_den_reg == '0);
    assign bypass_c = (mix_c == '0) || neutral;

    assign s_tready  = (state_reg == T_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Read position wrapped into the line; the offset never spans two line lengths.
    assign p0     = (OFF_W'({1'b0, wi_reg}) <<< 16) - offset_reg;
    assign p_add1 = p0 + SPAN;
    assign p_add2 = p0 + (SPAN <<< 1);
    assign p_sub1 = p0 - SPAN;
    always_comb
    begin
        if (p0 < 0)
        begin
            pos_c = (p_add1 < 0) ? p_add2 : p_add1;
        end
        else
        begin
            pos_c = (p0 >= SPAN) ? p_sub1 : p0;
        end
    end

    assign i0_c = pos_reg[16 +: AW];
    assign i1_c = (i0_c == AW'(LINE_LENGTH - 1)) ? '0 : i0_c + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  if (in_acc) state_next = bypass_c ? T_OUT : T_SINEW;
            T_SINEW: state_next = T_SINEF;
            T_SINEF: state_next = T_MULT;
            T_MULT:  state_next = T_OFFS;
            T_OFFS:  state_next = T_POS;
            T_POS:   state_next = T_ADDR;
            T_ADDR:  state_next = T_LANES;
            T_LANES: if (done_l && done_r) state_next = T_OUT;
            T_OUT:   if (!m_tvalid_reg || m_tready) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            wow_depth_reg     <= '0;
            flutter_depth_reg <= '0;
            sat_amount_reg    <= '0;
            wet_mix_reg       <= '0;
            shelf_num_reg     <= twf_pkg::NUM_IDENTITY;
            shelf_den_reg     <= '0;
            bump_num_reg      <= twf_pkg::NUM_IDENTITY;
            bump_den_reg      <= '0;
            wow_phase_reg     <= '0;
            flutter_phase_reg <= '0;
            wi_reg            <= '0;
            wrapped_reg       <= 1'b0;
            cmd_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg.start <= (state_reg == T_ADDR);

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    twf_pkg::REG_WOW_DEPTH:     wow_depth_reg     <= cfg_data[15:0];
                    twf_pkg::REG_FLUTTER_DEPTH: flutter_depth_reg <= cfg_data[12:0];
                    twf_pkg::REG_SAT_AMOUNT:    sat_amount_reg    <= cfg_data[16:0];
                    twf_pkg::REG_WET_MIX:       wet_mix_reg       <= cfg_data[16:0];
                    twf_pkg::REG_SHELF_NUM:     shelf_num_reg     <= cfg_data[62:0];
                    twf_pkg::REG_SHELF_DEN:     shelf_den_reg     <= cfg_data[47:0];
                    twf_pkg::REG_BUMP_NUM:      bump_num_reg      <= cfg_data[62:0];
                    twf_pkg::REG_BUMP_DEN:      bump_den_reg      <= cfg_data[47:0];
                    default: ;
                endcase
            end

            if (in_acc && !bypass_c)
            begin
                wow_phase_reg     <= wow_phase_reg + WOW_INC;
                flutter_phase_reg <= flutter_phase_reg + FLUTTER_INC;
            end

            if (state_reg == T_ADDR)
            begin
                cmd_reg.wr_addr  <= twf_pkg::CMD_ADDR_W'(wi_reg);
                cmd_reg.rd_addr0 <= twf_pkg::CMD_ADDR_W'(i0_c);
                cmd_reg.rd_addr1 <= twf_pkg::CMD_ADDR_W'(i1_c);
                // Entries past the write head have not been written since reset.
                cmd_reg.ok0      <= wrapped_reg || (i0_c <= wi_reg);
                cmd_reg.ok1      <= wrapped_reg || (i1_c <= wi_reg);
                cmd_reg.frac     <= pos_reg[15:0];
            end

            if (state_reg == T_LANES && done_l && done_r)
            begin
                if (wi_reg == AW'(LINE_LENGTH - 1))
                begin
                    wi_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wi_reg <= wi_reg + 1'b1;
                end
            end

            if (state_reg == T_OUT && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dry_l_reg  <= $signed(s_tdata[23:0]);
            dry_r_reg  <= $signed(s_tdata[47:24]);
            bypass_reg <= bypass_c;
        end
        unique case (state_reg)
            T_SINEW: sine_reg <= sine_rom[wow_idx];
            T_SINEF:
            begin
                wow_term_reg <= ($signed({1'b0, wow_depth_reg}) * 33'(sine_reg)) >>> 7;
                sine_reg     <= sine_rom[fl_idx];
            end
            T_MULT:  fl_term_reg <= ($signed({1'b0, flutter_depth_reg}) * 33'(sine_reg)) >>> 7;
            T_OFFS:  offset_reg <= BASE_Q + OFF_W'(wow_term_reg) + OFF_W'(fl_term_reg);
            T_POS:   pos_reg <= pos_c;
            T_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_reg <= bypass_reg ? {dry_r_reg, dry_l_reg} : {res_r, res_l};
                end
            end
            default: ;
        endcase
    end

    twf_lane #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd_reg),
        .dry    (dry_l_reg),
        .done   (done_l),
        .result (res_l)
    );

    twf_lane #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd_reg),
        .dry    (dry_r_reg),
        .done   (done_r),
        .result (res_r)
    );

endmodule

`default_nettype wire

// ----- rtl/twf_ram.sv -----
// Generic single-port RAM with registered read data.
// Used by twf_lane for the delay line; depends on nothing else.
`default_nettype none

module twf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- rtl/twf_lane.sv -----
// One channel of the tape effect: delay line, interpolation, soft clip divider,
// two biquads and the dry/wet mix over one shared multiplier.
// Depends on twf_pkg and twf_ram.
`default_nettype none

module twf_lane #(
    parameter int LINE_LENGTH = twf_pkg::LINE_LENGTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire twf_pkg::twf_cfg_t  cfg,
    input  wire twf_pkg::twf_cmd_t  cmd,
    input  wire logic signed [23:0] dry,
    output logic                    done,
    output logic signed [23:0]      result
);

    localparam int AW = $clog2(LINE_LENGTH);

    typedef enum logic [14:0] {
        L_IDLE   = 15'h0001,
        L_WRITE  = 15'h0002,
        L_RD0    = 15'h0004,
        L_RD1    = 15'h0008,
        L_RDB    = 15'h0010,
        L_INTERP = 15'h0020,
        L_YSUM   = 15'h0040,
        L_DRIVE  = 15'h0080,
        L_DEN    = 15'h0100,
        L_DIV    = 15'h0200,
        L_BLEND  = 15'h0400,
        L_BSUM   = 15'h0800,
        L_BIQUAD = 15'h1000,
        L_MIX    = 15'h2000,
        L_MSUM   = 15'h4000
    } lane_state_t;

    lane_state_t state_reg, state_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [23:0]                  ram_rdata;

    logic signed [23:0]           a_reg, b_reg, y_reg;
    logic [23:0]                  mag_reg;
    logic [26:0]                  den_reg, rem_reg;
    logic [23:0]                  num_reg, quo_reg;
    logic [4:0]                   cnt_reg;
    logic signed [57:0]           prod_reg;
    logic signed [32:0]           x_reg;
    logic signed [31:0]           yb_reg;
    logic signed [twf_pkg::ACC_W-1:0] acc1_reg, acc2_reg;
    logic [2:0]                   step_reg;
    logic                         flt_reg;
    logic signed [31:0]           z0_reg [2];
    logic signed [31:0]           z1_reg [2];
    logic                         done_reg;
    logic signed [23:0]           result_reg;

    logic signed [24:0]           mul_a;
    logic signed [32:0]           mul_b;
    logic [23:0]                  mag_c;
    logic signed [24:0]           sat_c;
    logic [27:0]                  div_t;
    logic                         div_ge;
    logic signed [24:0]           c_b0, c_b1, c_b2, c_a1, c_a2;
    logic signed [twf_pkg::ACC_W-1:0] sh16, sh19, sh21, mix_o;

    assign done   = done_reg;
    assign result = result_reg;

    twf_ram #(
        .WIDTH (24),
        .DEPTH (LINE_LENGTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (dry),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we   = (state_reg == L_WRITE);
        ram_addr = cmd.wr_addr[AW-1:0];
        if (state_reg == L_RD0)
        begin
            ram_addr = cmd.rd_addr0[AW-1:0];
        end
        else if (state_reg == L_RD1)
        begin
            ram_addr = cmd.rd_addr1[AW-1:0];
        end
    end

    assign mag_c  = y_reg[23] ? 24'(-y_reg) : 24'(y_reg);
    assign sat_c  = y_reg[23] ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign div_t  = {rem_reg, num_reg[23]};
    assign div_ge = (div_t >= {1'b0, den_reg});

    assign c_b0 = 25'($signed(cfg.num[flt_reg][62:42]));
    assign c_b1 = 25'($signed(cfg.num[flt_reg][41:21]));
    assign c_b2 = 25'($signed(cfg.num[flt_reg][20:0]));
    assign c_a1 = 25'($signed(cfg.den[flt_reg][47:24]));
    assign c_a2 = 25'($signed(cfg.den[flt_reg][23:0]));

    assign sh16  = twf_pkg::ACC_W'(prod_reg >>> 16);
    assign sh19  = twf_pkg::ACC_W'(prod_reg >>> 19);
    assign sh21  = twf_pkg::ACC_W'(prod_reg >>> 21);
    assign mix_o = cfg.mix_full ? twf_pkg::ACC_W'(x_reg)
                                : twf_pkg::ACC_W'(dry) + sh16;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            L_INTERP:
            begin
                mul_a = 25'(b_reg) - 25'(a_reg);
                mul_b = $signed({17'd0, cmd.frac});
            end
            L_DRIVE:
            begin
                mul_a = $signed({1'b0, mag_c});
                mul_b = $signed({13'd0, cfg.drive});
            end
            L_BLEND:
            begin
                mul_a = sat_c - 25'(y_reg);
                mul_b = $signed({16'd0, cfg.sat_s});
            end
            L_BIQUAD:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = c_b0; mul_b = x_reg;       end
                    3'd1:    begin mul_a = c_b1; mul_b = x_reg;       end
                    3'd2:    begin mul_a = c_a1; mul_b = 33'(yb_reg); end
                    3'd3:    begin mul_a = c_b2; mul_b = x_reg;       end
                    3'd4:    begin mul_a = c_a2; mul_b = 33'(yb_reg); end
                    default: begin mul_a = '0;   mul_b = '0;          end
                endcase
            end
            L_MIX:
            begin
                mul_a = $signed({8'd0, cfg.mix});
                mul_b = x_reg - 33'(dry);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:   if (cmd.start) state_next = L_WRITE;
            L_WRITE:  state_next = L_RD0;
            L_RD0:    state_next = L_RD1;
            L_RD1:    state_next = L_RDB;
            L_RDB:    state_next = L_INTERP;
            L_INTERP: state_next = L_YSUM;
            L_YSUM:   state_next = L_DRIVE;
            L_DRIVE:  state_next = L_DEN;
            L_DEN:    state_next = L_DIV;
            L_DIV:    if (cnt_reg == 5'd23) state_next = L_BLEND;
            L_BLEND:  state_next = L_BSUM;
            L_BSUM:   state_next = L_BIQUAD;
            L_BIQUAD: if (step_reg == 3'd5 && flt_reg) state_next = L_MIX;
            L_MIX:    state_next = L_MSUM;
            L_MSUM:   state_next = L_IDLE;
            default:  state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                z0_reg[i] <= '0;
                z1_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_MSUM);
            if (state_reg == L_BIQUAD && step_reg == 3'd5)
            begin
                z0_reg[flt_reg] <= twf_pkg::sat32(acc1_reg);
                z1_reg[flt_reg] <= twf_pkg::sat32(acc2_reg - sh21);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            L_RD1:  a_reg <= cmd.ok0 ? $signed(ram_rdata) : '0;
            L_RDB:  b_reg <= cmd.ok1 ? $signed(ram_rdata) : '0;
            L_YSUM: y_reg <= 24'(twf_pkg::ACC_W'(a_reg) + sh16);
            L_DRIVE: mag_reg <= mag_c;
            L_DEN:
            begin
                // Quotient fits 24 bits, so the top of the dividend starts as the remainder.
                den_reg <= 27'(prod_reg >>> 16) + 27'd8388608;
                rem_reg <= 27'(mag_reg[23:1]);
                num_reg <= {mag_reg[0], 23'd0};
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            L_DIV:
            begin
                rem_reg <= div_ge ? 27'(div_t - {1'b0, den_reg}) : 27'(div_t);
                quo_reg <= {quo_reg[22:0], div_ge};
                num_reg <= {num_reg[22:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            L_BSUM:
            begin
                x_reg    <= 33'(twf_pkg::ACC_W'(y_reg) + sh16);
                step_reg <= '0;
                flt_reg  <= 1'b0;
            end
            L_BIQUAD:
            begin
                case (step_reg)
                    3'd1: yb_reg <= twf_pkg::sat32(sh19 + twf_pkg::ACC_W'(z0_reg[flt_reg]));
                    3'd2: acc1_reg <= sh19 + twf_pkg::ACC_W'(z1_reg[flt_reg]);
                    3'd3: acc1_reg <= acc1_reg - sh21;
                    3'd4: acc2_reg <= sh19;
                    default: ;
                endcase
                if (step_reg == 3'd5)
                begin
                    x_reg    <= 33'(yb_reg);
                    step_reg <= '0;
                    flt_reg  <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
            L_MSUM: result_reg <= twf_pkg::sat24(mix_o);
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- dv/tape_wow_flutter_saturation_tb.sv -----
// Self-checking testbench for the tape wow/flutter/saturation block.
// Predicts each stereo result in a local model of the delay line, the oscillators,
// the soft clip, both biquads and the mix. Depends on twf_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

module tape_wow_flutter_saturation_tb;

    localparam int LINE_LEN   = 2048;
    localparam int TABLE_SIZE = 1024;
    localparam int BASE_DLY   = 576;
    localparam int RATE       = 48000;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [31:0] WOW_STEP =
        32'((((64'd7) << 32) + 64'd5 * RATE) / (64'd10 * RATE));
    localparam logic [31:0] FLUTTER_STEP =
        32'((((64'd9) << 32) + RATE / 2) / RATE);

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [63:0] cfg_data;

    tape_wow_flutter_saturation dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic signed [23:0] right;
        logic signed [23:0] left;
    } stereo_t;

    // Predictor state.
    logic signed [15:0] sine_tab [TABLE_SIZE];
    logic signed [23:0] line_mem [2][LINE_LEN];
    int unsigned        wr_pos;
    logic [31:0]        wow_ph, flutter_ph;
    longint             shelf_z [4];
    longint             bump_z [4];
    longint unsigned    set_wow, set_flutter, set_sat, set_mix;
    longint unsigned    set_num [2];
    longint unsigned    set_den [2];

    stereo_t pending_pairs [$];
    stereo_t expected_pairs [$];
    int      fail_count = 0;
    int      result_count = 0;
    int      stall_count;

    bit      rx_idle_on;
    bit      tx_idle_on;
    bit      hold_off_req;
    int      hold_off_cycles;
    int      rx_burst, tx_burst;

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sext(longint unsigned v, int bits);
        longint unsigned m;
        m = (64'd1 << bits) - 1;
        v = v & m;
        if (v[bits-1]) return longint'(v) - longint'(64'd1 << bits);
        return longint'(v);
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [15:0] sine_value(int unsigned k);
        longint unsigned u;
        longint r, x, x2, t, s;
        u = (longint'(k) << 32) / TABLE_SIZE;
        r = longint'(u & 64'h3FFF_FFFF);
        if (u[30]) r = twf_pkg::ONE_Q30 - r;
        x  = (r * twf_pkg::HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t  = twf_pkg::ONE_Q30 - x2 / 72;
        t  = twf_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = twf_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = twf_pkg::ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        s  = (s + 16384) >>> 15;
        if (s > 32767) s = 32767;
        if (u[31]) s = -s;
        return 16'(s);
    endfunction

    function automatic longint run_biquad(int sel, int ch, longint x);
        longint b0, b1, b2, a1, a2, y, n1, n2, z1, z2;
        b0 = sext(set_num[sel] >> 42, 21);
        b1 = sext(set_num[sel] >> 21, 21);
        b2 = sext(set_num[sel], 21);
        a1 = sext(set_den[sel] >> 24, 24);
        a2 = sext(set_den[sel], 24);
        z1 = sel == 0 ? shelf_z[2*ch] : bump_z[2*ch];
        z2 = sel == 0 ? shelf_z[2*ch+1] : bump_z[2*ch+1];
        y  = clampv(fshift(b0 * x, 19) + z1, -64'sd2147483648, 64'sd2147483647);
        n1 = fshift(b1 * x, 19) - fshift(a1 * y, 21) + z2;
        n2 = fshift(b2 * x, 19) - fshift(a2 * y, 21);
        n1 = clampv(n1, -64'sd2147483648, 64'sd2147483647);
        n2 = clampv(n2, -64'sd2147483648, 64'sd2147483647);
        if (sel == 0) begin
            shelf_z[2*ch] = n1;
            shelf_z[2*ch+1] = n2;
        end else begin
            bump_z[2*ch] = n1;
            bump_z[2*ch+1] = n2;
        end
        return y;
    endfunction

    // Computes the processed stereo pair; unless bypassed, advances the tape state.
    function automatic stereo_t tape_process(stereo_t pair);
        stereo_t res;
        longint dry [2];
        longint mix, amt, drive, offset, pos, frac, span;
        longint a, b, y, mag, satv, o;
        int unsigned i0, i1;
        bit neutral;
        mix = set_mix > 65536 ? 65536 : longint'(set_mix);
        amt = set_sat > 65536 ? 65536 : longint'(set_sat);
        dry[0] = pair.left;
        dry[1] = pair.right;
        neutral = set_wow == 0 && set_flutter == 0 && amt == 0
            && set_num[0] == twf_pkg::NUM_IDENTITY && set_den[0] == 0
            && set_num[1] == twf_pkg::NUM_IDENTITY && set_den[1] == 0;
        if (mix == 0 || neutral) return pair;
        wow_ph += WOW_STEP;
        flutter_ph += FLUTTER_STEP;
        span   = longint'(LINE_LEN) << 16;
        drive  = 65536 + 7 * amt;
        offset = (longint'(BASE_DLY) << 16)
            + fshift(longint'(set_wow) * sine_tab[wow_ph[31:22]], 7)
            + fshift(longint'(set_flutter) * sine_tab[flutter_ph[31:22]], 7);
        pos = ((longint'(wr_pos) << 16) - offset) % span;
        if (pos < 0) pos += span;
        i0   = int'(pos >> 16);
        frac = pos & 64'hFFFF;
        i1   = (i0 + 1) % LINE_LEN;
        for (int ch = 0; ch < 2; ch++) begin
            line_mem[ch][wr_pos] = 24'(dry[ch]);
            a = line_mem[ch][i0];
            b = line_mem[ch][i1];
            y = a + fshift((b - a) * frac, 16);
            mag = y < 0 ? -y : y;
            satv = (mag << 23) / ((64'sd1 << 23) + ((mag * drive) >>> 16));
            if (y < 0) satv = -satv;
            y = y + fshift((satv - y) * amt, 16);
            y = run_biquad(0, ch, y);
            y = run_biquad(1, ch, y);
            if (mix >= 65536) o = y;
            else o = dry[ch] + fshift((y - dry[ch]) * mix, 16);
            o = clampv(o, -8388608, 8388607);
            if (ch == 0) res.left = 24'(o);
            else res.right = 24'(o);
        end
        wr_pos = (wr_pos + 1) % LINE_LEN;
        return res;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Request driver: predicts each pair at acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_burst <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pairs.push_back(tape_process(stereo_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_burst > 0) begin
                    tx_burst <= tx_burst - 1;
                    s_tvalid <= 1'b0;
                end else if (tx_idle_on && $urandom_range(0, 9) == 0) begin
                    tx_burst <= $urandom_range(1, 12) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        stereo_t got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_burst <= 0;
            stall_count <= 0;
            hold_off_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = stereo_t'(m_tdata);
                result_count = result_count + 1;
                if (expected_pairs.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_out expected %0d got %0d", want.left, got.left);
                        fail_count = fail_count + 1;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out expected %0d got %0d", want.right, got.right);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
            else stall_count <= stall_count + 1;
            if (hold_off_req && hold_off_cycles == 0) begin
                hold_off_cycles <= 400;
                m_tready <= 1'b0;
            end else if (hold_off_cycles > 1) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 1'b0;
            end else if (rx_burst > 0) begin
                rx_burst <= rx_burst - 1;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                rx_burst <= $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                if (hold_off_cycles == 1) hold_off_cycles <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_count >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_tvalid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(twf_pkg::twf_reg_t idx, longint unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            twf_pkg::REG_WOW_DEPTH:     set_wow = value & 64'hFFFF;
            twf_pkg::REG_FLUTTER_DEPTH: set_flutter = value & 64'h1FFF;
            twf_pkg::REG_SAT_AMOUNT:    set_sat = value & 64'h1FFFF;
            twf_pkg::REG_WET_MIX:       set_mix = value & 64'h1FFFF;
            twf_pkg::REG_SHELF_NUM:     set_num[0] = value & 64'h7FFF_FFFF_FFFF_FFFF;
            twf_pkg::REG_SHELF_DEN:     set_den[0] = value & 64'hFFFF_FFFF_FFFF;
            twf_pkg::REG_BUMP_NUM:      set_num[1] = value & 64'h7FFF_FFFF_FFFF_FFFF;
            twf_pkg::REG_BUMP_DEN:      set_den[1] = value & 64'hFFFF_FFFF_FFFF;
            default: ;
        endcase
    endtask

    function automatic logic [20:0] coef21(int v);
        return 21'(v);
    endfunction

    function automatic logic [23:0] coef24(int v);
        return 24'(v);
    endfunction

    // Mild, stable filters: b0 around 1.0 and small b1, b2 in Q2.19, small a terms in Q3.21.
    task automatic random_filters();
        write_setting(twf_pkg::REG_SHELF_NUM,
            {1'b0, coef21(int'($urandom_range(300000, 700000))),
            coef21($urandom_range(0, 200000) - 100000),
            coef21($urandom_range(0, 100000) - 50000)});
        write_setting(twf_pkg::REG_SHELF_DEN, {coef24($urandom_range(0, 800000) - 400000),
            coef24($urandom_range(0, 400000) - 200000)});
        write_setting(twf_pkg::REG_BUMP_NUM,
            {1'b0, coef21(int'($urandom_range(300000, 700000))),
            coef21($urandom_range(0, 200000) - 100000),
            coef21($urandom_range(0, 100000) - 50000)});
        write_setting(twf_pkg::REG_BUMP_DEN, {coef24($urandom_range(0, 800000) - 400000),
            coef24($urandom_range(0, 400000) - 200000)});
    endtask

    task automatic queue_pair(logic [23:0] l, logic [23:0] r);
        pending_pairs.push_back({r, l});
    endtask

    task automatic queue_random(int count);
        logic [23:0] l, r;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    l = 24'($urandom);
                    r = 24'($urandom);
                end
                1: begin
                    l = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
                    r = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
                end
                default: begin
                    // Smooth-ish audio so interpolation and filters see real signal.
                    l = 24'(sine_tab[(i * 7) % TABLE_SIZE] * $urandom_range(1, 255));
                    r = 24'(sine_tab[(i * 13) % TABLE_SIZE] * $urandom_range(1, 255));
                end
            endcase
            queue_pair(l, r);
        end
    endtask

    initial
    begin
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        hold_off_req = 1'b0;
        for (int k = 0; k < TABLE_SIZE; k++) sine_tab[k] = sine_value(k);
        for (int k = 0; k < LINE_LEN; k++) begin
            line_mem[0][k] = '0;
            line_mem[1][k] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            shelf_z[k] = 0;
            bump_z[k] = 0;
        end
        wr_pos = 0;
        wow_ph = '0;
        flutter_ph = '0;
        set_wow = 0; set_flutter = 0; set_sat = 0; set_mix = 0;
        set_num[0] = twf_pkg::NUM_IDENTITY; set_num[1] = twf_pkg::NUM_IDENTITY;
        set_den[0] = 0; set_den[1] = 0;
        cfg_valid = 1'b0;
        cfg_index = twf_pkg::REG_WOW_DEPTH;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass at reset defaults, then field extremes.
        queue_pair(24'h7F_FFFF, 24'h80_0000);
        queue_pair(24'h80_0000, 24'h7F_FFFF);
        queue_pair(24'h00_0000, 24'hFF_FFFF);
        wait_drained();

        // Full wet with extreme depths and drive above full scale.
        write_setting(twf_pkg::REG_WET_MIX, 17'h1FFFF);
        write_setting(twf_pkg::REG_WOW_DEPTH, 16'hFFFF);
        write_setting(twf_pkg::REG_FLUTTER_DEPTH, 13'h1FFF);
        write_setting(twf_pkg::REG_SAT_AMOUNT, 17'h1FFFF);
        for (int i = 0; i < 6; i++) begin
            queue_pair(24'h7F_FFFF, 24'h80_0000);
            queue_pair(24'h80_0000, 24'h7F_FFFF);
        end
        queue_pair(24'h00_0001, 24'hFF_FFFF);
        wait_drained();

        // Unknown index is ignored; neutral settings bypass even with mix set.
        write_setting(twf_pkg::twf_reg_t'(4'd9), 64'hFFFF_FFFF_FFFF_FFFF);
        write_setting(twf_pkg::REG_WOW_DEPTH, 0);
        write_setting(twf_pkg::REG_FLUTTER_DEPTH, 0);
        write_setting(twf_pkg::REG_SAT_AMOUNT, 0);
        queue_pair(24'h12_3456, 24'hED_CBA9);
        queue_pair(24'h7F_FFFF, 24'h80_0000);
        wait_drained();

        // Filters with extreme coefficient fields (state saturation).
        write_setting(twf_pkg::REG_SHELF_NUM, 64'h7FFF_FFFF_FFFF_FFFF);
        write_setting(twf_pkg::REG_SHELF_DEN, 64'hFFFF_FFFF_FFFF);
        write_setting(twf_pkg::REG_BUMP_NUM, 64'h4000_0200_0001_0000);
        write_setting(twf_pkg::REG_BUMP_DEN, 64'h8000_0080_0000);
        queue_random(4);
        wait_drained();

        // Random phases over several settings; partial mix, then the receiver
        // holds off long enough for the block to back up its input.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                rx_idle_on = 1'b0;
                tx_idle_on = 1'b0;
            end
            write_setting(twf_pkg::REG_WET_MIX,
                phase == 0 ? 17'd1 : $urandom_range(0, 65536));
            write_setting(twf_pkg::REG_WOW_DEPTH, $urandom_range(0, 43008));
            write_setting(twf_pkg::REG_FLUTTER_DEPTH, $urandom_range(0, 4301));
            write_setting(twf_pkg::REG_SAT_AMOUNT, $urandom_range(0, 65536));
            random_filters();
            queue_random(220);
            if (phase == 2) begin
                hold_off_req = 1'b1;
                wait (hold_off_cycles > 0);
                hold_off_req = 1'b0;
            end
            wait_drained();
        end

        $display("covered bypass, neutral and wet settings, extreme depths and drive,");
        $display("%0d results checked across several filter settings", result_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
